[hdl/ptl_pkg.sv]
// Package for the pixel transfer layout block: GL format and type codes, status
// codes, register indexes, the queued job type and the pixel size lookup.
// No dependencies.
package ptl_pkg;

   localparam int CFG_IDX_W  = 3;
   localparam int CFG_DATA_W = 31;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   localparam logic [CFG_IDX_W-1:0] REG_PACK_ALIGN      = 3'd0;
   localparam logic [CFG_IDX_W-1:0] REG_UNPACK_ALIGN    = 3'd1;
   localparam logic [CFG_IDX_W-1:0] REG_PACK_ROW_LEN    = 3'd2;
   localparam logic [CFG_IDX_W-1:0] REG_UNPACK_ROW_LEN  = 3'd3;
   localparam logic [CFG_IDX_W-1:0] REG_PACK_ROWS_SKIP  = 3'd4;
   localparam logic [CFG_IDX_W-1:0] REG_PACK_PIX_SKIP   = 3'd5;
   localparam logic [CFG_IDX_W-1:0] REG_UNPACK_ROWS_SKIP = 3'd6;
   localparam logic [CFG_IDX_W-1:0] REG_UNPACK_PIX_SKIP = 3'd7;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_NEG_SIZE   = 3'd1;
   localparam logic [2:0] ST_BAD_FORMAT = 3'd2;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd3;
   localparam logic [2:0] ST_MISMATCH   = 3'd4;
   localparam logic [2:0] ST_OVERFLOW   = 3'd5;

   localparam logic [15:0] FMT_ALPHA           = 16'h1906;
   localparam logic [15:0] FMT_LUMINANCE       = 16'h1909;
   localparam logic [15:0] FMT_DEPTH           = 16'h1902;
   localparam logic [15:0] FMT_RED             = 16'h1903;
   localparam logic [15:0] FMT_RED_INTEGER     = 16'h8D94;
   localparam logic [15:0] FMT_LUMINANCE_ALPHA = 16'h190A;
   localparam logic [15:0] FMT_RG              = 16'h8227;
   localparam logic [15:0] FMT_RG_INTEGER      = 16'h8228;
   localparam logic [15:0] FMT_RGB             = 16'h1907;
   localparam logic [15:0] FMT_RGB_INTEGER     = 16'h8D98;
   localparam logic [15:0] FMT_RGBA            = 16'h1908;
   localparam logic [15:0] FMT_BGRA            = 16'h80E1;
   localparam logic [15:0] FMT_RGBA_INTEGER    = 16'h8D99;

   localparam logic [15:0] TYP_UBYTE        = 16'h1401;
   localparam logic [15:0] TYP_BYTE         = 16'h1400;
   localparam logic [15:0] TYP_USHORT       = 16'h1403;
   localparam logic [15:0] TYP_SHORT        = 16'h1402;
   localparam logic [15:0] TYP_HALF         = 16'h140B;
   localparam logic [15:0] TYP_HALF_OES     = 16'h8D61;
   localparam logic [15:0] TYP_UINT         = 16'h1405;
   localparam logic [15:0] TYP_INT          = 16'h1404;
   localparam logic [15:0] TYP_FLOAT        = 16'h1406;
   localparam logic [15:0] TYP_US_565       = 16'h8363;
   localparam logic [15:0] TYP_US_4444      = 16'h8033;
   localparam logic [15:0] TYP_US_5551      = 16'h8034;
   localparam logic [15:0] TYP_UI_2101010   = 16'h8368;
   localparam logic [15:0] TYP_UI_10F11F11F = 16'h8C3B;
   localparam logic [15:0] TYP_UI_5999      = 16'h8C3E;
   localparam logic [15:0] TYP_UI_24_8      = 16'h84FA;
   localparam logic [15:0] TYP_F32_UI_24_8  = 16'h8DAD;

   typedef struct packed {
      logic [2:0] status;
      logic [4:0] px;
   } px_info_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        blank;
      logic [4:0]  px;
      logic [30:0] width;
      logic [30:0] height;
      logic [30:0] row_len;
      logic [3:0]  align;
      logic [30:0] rows_skip;
      logic [30:0] pix_skip;
   } job_type;

   typedef struct packed {
      logic [63:0] start_offset;
      logic [63:0] line_pitch;
      logic [63:0] row_size;
      logic [63:0] total_size;
      logic [30:0] row_count;
      logic [2:0]  status;
   } result_type;

   function automatic logic [2:0] comp_count(input logic [15:0] fmt);
      logic [2:0] n;
      case (fmt)
         FMT_ALPHA, FMT_LUMINANCE, FMT_DEPTH, FMT_RED, FMT_RED_INTEGER: n = 3'd1;
         FMT_LUMINANCE_ALPHA, FMT_RG, FMT_RG_INTEGER: n = 3'd2;
         FMT_RGB, FMT_RGB_INTEGER: n = 3'd3;
         FMT_RGBA, FMT_BGRA, FMT_RGBA_INTEGER: n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic px_info_type px_lookup(input logic [15:0] fmt,
                                             input logic [15:0] typ);
      px_info_type r;
      logic [4:0]  unit;
      logic [2:0]  n;
      r.status = ST_OK;
      r.px     = 5'd0;
      unit     = 5'd0;
      n        = comp_count(fmt);
      case (typ)
         TYP_UBYTE, TYP_BYTE: unit = 5'd1;
         TYP_USHORT, TYP_SHORT, TYP_HALF, TYP_HALF_OES: unit = 5'd2;
         TYP_UINT, TYP_INT, TYP_FLOAT: unit = 5'd4;
         TYP_US_565: begin
            if (fmt != FMT_RGB) r.status = ST_MISMATCH;
            else r.px = 5'd2;
         end
         TYP_US_4444, TYP_US_5551: begin
            if (fmt != FMT_RGBA && fmt != FMT_BGRA) r.status = ST_MISMATCH;
            else r.px = 5'd2;
         end
         TYP_UI_2101010, TYP_UI_10F11F11F, TYP_UI_5999, TYP_UI_24_8: r.px = 5'd4;
         TYP_F32_UI_24_8: r.px = 5'd8;
         default: r.status = ST_BAD_TYPE;
      endcase
      if (unit != 5'd0) begin
         if (n == 3'd0) r.status = ST_BAD_FORMAT;
         else r.px = 5'(unit * {2'b00, n});
      end
      return r;
   endfunction

endpackage

[hdl/ptl_front.sv]
// Front end: holds the configuration registers and classifies each request
// into a queued job (status, pixel size, selected pack or unpack settings).
// Depends on ptl_pkg.
module ptl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [ptl_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [ptl_pkg::CFG_DATA_W-1:0]   csr_wdata,
   input  logic                             mode,
   input  logic [31:0]                      img_width,
   input  logic [31:0]                      img_height,
   input  logic [15:0]                      pix_format,
   input  logic [15:0]                      pix_type,
   output ptl_pkg::job_type                 job
);

   logic [3:0]  pack_align_ff, unpack_align_ff;
   logic [30:0] pack_row_len_ff, unpack_row_len_ff;
   logic [30:0] pack_rows_skip_ff, pack_pix_skip_ff;
   logic [30:0] unpack_rows_skip_ff, unpack_pix_skip_ff;

   logic [3:0]           align_in;
   logic                 align_ok;
   logic                 neg;
   logic                 zero;
   ptl_pkg::px_info_type info;

   assign align_in = csr_wdata[3:0];
   assign align_ok = (align_in == 4'd1) || (align_in == 4'd2) ||
                     (align_in == 4'd4) || (align_in == 4'd8);

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_align_ff       <= 4'd4;
         unpack_align_ff     <= 4'd4;
         pack_row_len_ff     <= '0;
         unpack_row_len_ff   <= '0;
         pack_rows_skip_ff   <= '0;
         pack_pix_skip_ff    <= '0;
         unpack_rows_skip_ff <= '0;
         unpack_pix_skip_ff  <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            ptl_pkg::REG_PACK_ALIGN: begin
               if (align_ok) pack_align_ff <= align_in;
            end
            ptl_pkg::REG_UNPACK_ALIGN: begin
               if (align_ok) unpack_align_ff <= align_in;
            end
            ptl_pkg::REG_PACK_ROW_LEN:     pack_row_len_ff     <= csr_wdata;
            ptl_pkg::REG_UNPACK_ROW_LEN:   unpack_row_len_ff   <= csr_wdata;
            ptl_pkg::REG_PACK_ROWS_SKIP:   pack_rows_skip_ff   <= csr_wdata;
            ptl_pkg::REG_PACK_PIX_SKIP:    pack_pix_skip_ff    <= csr_wdata;
            ptl_pkg::REG_UNPACK_ROWS_SKIP: unpack_rows_skip_ff <= csr_wdata;
            ptl_pkg::REG_UNPACK_PIX_SKIP:  unpack_pix_skip_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign neg  = img_width[31] | img_height[31];
   assign zero = (img_width == 32'd0) || (img_height == 32'd0);
   assign info = ptl_pkg::px_lookup(pix_format, pix_type);

   always_comb begin
      if (neg) job.status = ptl_pkg::ST_NEG_SIZE;
      else if (zero) job.status = ptl_pkg::ST_OK;
      else job.status = info.status;
      job.blank     = zero;
      job.px        = info.px;
      job.width     = img_width[30:0];
      job.height    = img_height[30:0];
      job.row_len   = mode ? pack_row_len_ff : unpack_row_len_ff;
      job.align     = mode ? pack_align_ff : unpack_align_ff;
      job.rows_skip = mode ? pack_rows_skip_ff : unpack_rows_skip_ff;
      job.pix_skip  = mode ? pack_pix_skip_ff : unpack_pix_skip_ff;
   end

endmodule

[hdl/ptl_fifo.sv]
// Short job queue between the front end and the back end.
// Depends on ptl_pkg.
module ptl_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ptl_pkg::job_type push_job,
   input  logic             pop,
   output ptl_pkg::job_type pop_job,
   output logic             not_empty,
   output logic             not_full
);

   ptl_pkg::job_type               mem_ff [ptl_pkg::FIFO_DEPTH];
   logic [ptl_pkg::FIFO_AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [ptl_pkg::FIFO_CW-1:0]    count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign not_full  = (count_ff != ptl_pkg::FIFO_CW'(ptl_pkg::FIFO_DEPTH));
   assign pop_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

[hdl/ptl_back.sv]
// Back end: four-stage layout datapath followed by an output register. The wide
// products are split into 31x18 partial products. Depends on ptl_pkg.
module ptl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_valid,
   input  ptl_pkg::job_type    job,
   output logic                job_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ptl_pkg::result_type rsp
);

   logic advance;

   // Stage 1: pixel products.
   logic        s1_valid_ff;
   logic [2:0]  s1_status_ff;
   logic        s1_blank_ff;
   logic [35:0] s1_raw_ff, s1_raw_in;
   logic [35:0] s1_row_ff, s1_row_in;
   logic [35:0] s1_poff_ff, s1_poff_in;
   logic [30:0] s1_hm1_ff, s1_h_ff, s1_rskip_ff;
   logic [3:0]  s1_align_ff;

   // Stage 2: aligned stride.
   logic        s2_valid_ff;
   logic [2:0]  s2_status_ff;
   logic        s2_blank_ff;
   logic [35:0] s2_stride_ff, s2_stride_in;
   logic [35:0] s2_row_ff, s2_poff_ff;
   logic [30:0] s2_hm1_ff, s2_h_ff, s2_rskip_ff;

   // Stage 3: partial products.
   logic        s3_valid_ff;
   logic [2:0]  s3_status_ff;
   logic        s3_blank_ff;
   logic [35:0] s3_stride_ff, s3_row_ff, s3_poff_ff;
   logic [30:0] s3_h_ff;
   logic [48:0] s3_rlo_ff, s3_rhi_ff, s3_hlo_ff, s3_hhi_ff;

   // Stage 4: offset and the remainder of the extent.
   logic        s4_valid_ff;
   logic [2:0]  s4_status_ff;
   logic        s4_blank_ff;
   logic [35:0] s4_stride_ff, s4_row_ff;
   logic [30:0] s4_h_ff;
   logic [67:0] s4_off_ff, s4_off_in;
   logic [67:0] s4_ext_ff, s4_ext_in;

   logic                rsp_valid_ff;
   ptl_pkg::result_type rsp_ff, rsp_in;
   logic [68:0]         total_in;
   logic [3:0]          am1;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign job_pop   = advance && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      s1_raw_in  = {5'd0, ((job.row_len == '0) ? job.width : job.row_len)} *
                   {31'd0, job.px};
      s1_row_in  = {5'd0, job.width} * {31'd0, job.px};
      s1_poff_in = {5'd0, job.pix_skip} * {31'd0, job.px};
   end

   assign am1 = s1_align_ff - 4'd1;
   always_comb begin
      s2_stride_in = 36'(s1_raw_ff + {32'd0, am1}) & {32'hFFFF_FFFF, ~am1};
   end

   always_comb begin
      s4_off_in = {1'b0, s3_rhi_ff, 18'd0} + {19'd0, s3_rlo_ff} + {32'd0, s3_poff_ff};
      s4_ext_in = {1'b0, s3_hhi_ff, 18'd0} + {19'd0, s3_hlo_ff} + {32'd0, s3_row_ff};
   end

   always_comb begin
      total_in = {1'b0, s4_off_ff} + {1'b0, s4_ext_ff};
      rsp_in   = '0;
      if (s4_status_ff != ptl_pkg::ST_OK || s4_blank_ff) begin
         rsp_in.status = s4_status_ff;
      end else if (total_in[68:64] != 5'd0) begin
         rsp_in.status = ptl_pkg::ST_OVERFLOW;
      end else begin
         rsp_in.start_offset = s4_off_ff[63:0];
         rsp_in.line_pitch   = {28'd0, s4_stride_ff};
         rsp_in.row_size     = {28'd0, s4_row_ff};
         rsp_in.total_size   = total_in[63:0];
         rsp_in.row_count    = s4_h_ff;
         rsp_in.status       = ptl_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_status_ff <= job.status;
         s1_blank_ff  <= job.blank;
         s1_raw_ff    <= s1_raw_in;
         s1_row_ff    <= s1_row_in;
         s1_poff_ff   <= s1_poff_in;
         s1_hm1_ff    <= job.height - 31'd1;
         s1_h_ff      <= job.height;
         s1_rskip_ff  <= job.rows_skip;
         s1_align_ff  <= job.align;

         s2_status_ff <= s1_status_ff;
         s2_blank_ff  <= s1_blank_ff;
         s2_stride_ff <= s2_stride_in;
         s2_row_ff    <= s1_row_ff;
         s2_poff_ff   <= s1_poff_ff;
         s2_hm1_ff    <= s1_hm1_ff;
         s2_h_ff      <= s1_h_ff;
         s2_rskip_ff  <= s1_rskip_ff;

         s3_status_ff <= s2_status_ff;
         s3_blank_ff  <= s2_blank_ff;
         s3_stride_ff <= s2_stride_ff;
         s3_row_ff    <= s2_row_ff;
         s3_poff_ff   <= s2_poff_ff;
         s3_h_ff      <= s2_h_ff;
         s3_rlo_ff    <= {18'd0, s2_rskip_ff} * {31'd0, s2_stride_ff[17:0]};
         s3_rhi_ff    <= {18'd0, s2_rskip_ff} * {31'd0, s2_stride_ff[35:18]};
         s3_hlo_ff    <= {18'd0, s2_hm1_ff} * {31'd0, s2_stride_ff[17:0]};
         s3_hhi_ff    <= {18'd0, s2_hm1_ff} * {31'd0, s2_stride_ff[35:18]};

         s4_status_ff <= s3_status_ff;
         s4_blank_ff  <= s3_blank_ff;
         s4_stride_ff <= s3_stride_ff;
         s4_row_ff    <= s3_row_ff;
         s4_h_ff      <= s3_h_ff;
         s4_off_ff    <= s4_off_in;
         s4_ext_ff    <= s4_ext_in;

         rsp_ff       <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         rsp_valid_ff <= s4_valid_ff;
      end
   end

endmodule

[hdl/pixel_transfer_layout.sv]
// Top level of the pixel transfer layout block: front end, job queue and
// back end. Depends on ptl_pkg, ptl_front, ptl_fifo and ptl_back.
//
// A request on the req_ channel describes one 2D pixel transfer; req_tuser
// selects pack (1) or unpack (0). Each request gives exactly one result on
// the rsp_ channel, in request order: start offset, row stride, row size,
// total size and row count, with a status code in rsp_tuser.
// The csr_ port writes the alignment, row length and skip registers; the user
// must write it only while no request is in flight, which the block does not enforce.
// An accepted request passes through the queue, the stage 1 to 4 registers and
// the output register to rsp_tvalid. While the receiver is ready the block
// takes one request per cycle, a rate set by the single layout pipeline.
// Reset loads the register defaults (alignment 4, everything else 0) and
// empties the queue and the pipeline.
// When the receiver stalls, the pipeline holds its contents and the
// four-entry queue keeps taking requests until it fills, then req_tready
// drops.
module pixel_transfer_layout (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wen,
   input  logic [ptl_pkg::CFG_IDX_W-1:0]    csr_index,
   input  logic [ptl_pkg::CFG_DATA_W-1:0]   csr_wdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // img_width[31:0], img_height[63:32], pix_format[79:64], pix_type[95:80]
   input  logic [95:0]                      req_tdata,
   // mode
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // start_offset[63:0], line_pitch[127:64], row_size[191:128],
   // total_size[255:192], row_count[286:256], zero[287]
   output logic [287:0]                     rsp_tdata,
   // status
   output logic [2:0]                       rsp_tuser
);

   ptl_pkg::job_type    front_job;
   ptl_pkg::job_type    queued_job;
   ptl_pkg::result_type result;
   logic                queue_valid;
   logic                queue_not_full;
   logic                queue_pop;
   logic                queue_push;

   assign req_tready = queue_not_full;
   assign queue_push = req_tvalid && queue_not_full;

   ptl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .mode       (req_tuser),
      .img_width  (req_tdata[31:0]),
      .img_height (req_tdata[63:32]),
      .pix_format (req_tdata[79:64]),
      .pix_type   (req_tdata[95:80]),
      .job        (front_job)
   );

   ptl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_job  (front_job),
      .pop       (queue_pop),
      .pop_job   (queued_job),
      .not_empty (queue_valid),
      .not_full  (queue_not_full)
   );

   ptl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (queue_valid),
      .job       (queued_job),
      .job_pop   (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   assign rsp_tdata = {1'b0, result.row_count, result.total_size, result.row_size,
                       result.line_pitch, result.start_offset};
   assign rsp_tuser = result.status;

endmodule
